// ===== rtl/grid_bilinear_interpolator_assert.svh =====
// Assertion macros for the grid bilinear interpolator.
`ifndef GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define GBI_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error(msg);

// Next-cycle implication checked outside reset.
`define GBI_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error(msg);

`endif

// ===== rtl/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg
// Types and constants shared by the grid bilinear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package gbi_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int REG_BITS       = 7;
	localparam int IDX_BITS       = 6;
	localparam int FRAC_BITS      = 24;
	localparam int DIV_BITS       = 50;

	localparam logic [1:0] OP_WRITE_X    = 2'd0;
	localparam logic [1:0] OP_WRITE_Y    = 2'd1;
	localparam logic [1:0] OP_WRITE_GRID = 2'd2;
	localparam logic [1:0] OP_QUERY      = 2'd3;

	localparam logic [0:0] CFG_X_USED = 1'b0;
	localparam logic [0:0] CFG_Y_USED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SPAN_RD,
		ST_SPAN_CAP,
		ST_DIV,
		ST_CORNER_RD,
		ST_ROW,
		ST_FINAL,
		ST_DONE
	} state_t;

	// Controls handed to the divider.
	typedef struct packed {
		logic                        start;
		logic signed [DIV_BITS-1:0]  num;
		logic signed [DIV_BITS-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                         done;
		logic signed [DIV_BITS-1:0]   quot;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/gbi_divider.sv =====
// ----------------------------------------------------------------------------
// gbi_divider
// Restoring signed divider, one quotient bit per cycle, rounding toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module gbi_divider (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gbi_pkg::div_req_t req,
	output gbi_pkg::div_rsp_t     rsp
);
	localparam int W = gbi_pkg::DIV_BITS;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W-1:0]  shifted;

	always_comb begin
		shifted = {rem_q[W-2:0], quo_q[W-1]};
		trial   = {1'b0, shifted} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num[W-1] ? W'(-req.num) : req.num;
			den_q <= req.den[W-1] ? W'(-req.den) : req.den;
			neg_q <= req.num[W-1] ^ req.den[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

// ===== rtl/gbi_store.sv =====
// ----------------------------------------------------------------------------
// gbi_store
// Axis and grid memories, each one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module gbi_store #(
	parameter int MAX_POINTS = gbi_pkg::MAX_POINTS_DEF,
	parameter int VW         = 32
) (
	input  wire logic                              clk,
	input  wire logic                              ax_we,
	input  wire logic                              ax_sel_y,
	input  wire logic [$clog2(MAX_POINTS)-1:0]     ax_waddr,
	input  wire logic [$clog2(MAX_POINTS)-1:0]     ax_raddr,
	input  wire logic signed [VW-1:0]              wdata,
	output logic signed [VW-1:0]                   x_rdata,
	output logic signed [VW-1:0]                   y_rdata,
	input  wire logic                              g_we,
	input  wire logic [2*$clog2(MAX_POINTS)-1:0]   g_waddr,
	input  wire logic [2*$clog2(MAX_POINTS)-1:0]   g_raddr,
	output logic signed [VW-1:0]                   g_rdata
);
	// The grid is addressed by the two indices side by side.
	localparam int G_DEPTH = 1 << (2 * $clog2(MAX_POINTS));

	logic signed [VW-1:0] x_mem [MAX_POINTS];
	logic signed [VW-1:0] y_mem [MAX_POINTS];
	logic signed [VW-1:0] g_mem [G_DEPTH];

	always_ff @(posedge clk) begin
		if (ax_we && !ax_sel_y) x_mem[ax_waddr] <= wdata;
		x_rdata <= x_mem[ax_raddr];
	end

	always_ff @(posedge clk) begin
		if (ax_we && ax_sel_y) y_mem[ax_waddr] <= wdata;
		y_rdata <= y_mem[ax_raddr];
	end

	always_ff @(posedge clk) begin
		if (g_we) g_mem[g_waddr] <= wdata;
		g_rdata <= g_mem[g_raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/grid_bilinear_interpolator.sv =====
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator
// Binary-search bracketing and bilinear blending over a loaded Q16.16 grid.
// ----------------------------------------------------------------------------
// Writes (opcodes 0 to 2) give no result. A query holds busy while each axis
// runs a binary search through its memory read port, a midpoint read and a
// compare per search step (six steps at most at MAX_POINTS = 64), closes the
// search and fetches the bracket, and divides in the shared bit-serial
// divider unless both bracket entries are equal; the four corners are then
// read from the grid memory and blended, and the result word is presented in
// the last busy cycle. The single result appears for one cycle on valid; the
// receiver cannot stall it. Register writes are held off while a query runs.
// Memories are not cleared: reading unwritten entries is undefined.
`default_nettype none
`include "grid_bilinear_interpolator_assert.svh"
module grid_bilinear_interpolator #(
	parameter int MAX_POINTS = gbi_pkg::MAX_POINTS_DEF,
	parameter int VALUE_BITS = gbi_pkg::VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [5:0]         first_index,
	input  wire logic [5:0]         second_index,
	input  wire logic signed [31:0] load_value,
	input  wire logic signed [31:0] query_x,
	input  wire logic signed [31:0] query_y,
	output logic                    valid,
	output logic signed [31:0]      interpolated,
	output logic [5:0]              x_low_index,
	output logic [5:0]              y_low_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [6:0]         cfg_data
);
	localparam int VW    = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int REACH = (MAX_POINTS < 64) ? MAX_POINTS : 64;
	localparam int DW    = gbi_pkg::DIV_BITS;
	localparam int FB    = gbi_pkg::FRAC_BITS;
	localparam logic signed [FB-1:0] HALF = FB'(32768);
	localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -(64'sd1 <<< (VW - 1));

	gbi_pkg::state_t state_q, state_d;

	logic [6:0]  xused_q, yused_q;
	logic        axis_q;              // 0 searching x, 1 searching y
	logic [6:0]  lo_q, hi_q;
	logic [6:0]  md;
	logic [AW-1:0] xlo_q, xhi_q, ylo_q;
	logic signed [31:0] qx_q, qy_q;
	logic signed [VW-1:0] alo_q;
	logic signed [FB-1:0] fx_q, fy_q;
	logic [1:0]  corner_q;
	logic [2:0]  cap_q;
	logic signed [VW-1:0] g00_q, g10_q, g01_q;
	logic signed [63:0] row_lo_q, row_hi_q;
	logic signed [31:0] res_q;

	logic                 ax_we, g_we;
	logic [AW-1:0]        ax_raddr;
	logic [2*AW-1:0]      g_raddr, g_waddr;
	logic signed [VW-1:0] x_rd, y_rd, g_rd, ax_rd;
	logic signed [31:0]   point;
	logic                 accept;
	logic signed [DW-1:0] span, diff;
	gbi_pkg::div_req_t    dreq;
	gbi_pkg::div_rsp_t    drsp;
	logic signed [FB-1:0] frac_sat, frac_cur;
	logic [AW-1:0]        ylo_c, yhi_c;

	assign accept    = start && !busy;
	assign cfg_ready = !busy && !start;
	assign busy      = (state_q != gbi_pkg::ST_IDLE);

	function automatic logic signed [63:0] blend(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic signed [FB-1:0] f);
		logic signed [63:0] acc;
		logic signed [63:0] r;
		acc = (a <<< 16) + (b - a) * 64'(f) + 64'sd32768;
		r = acc >>> 16;
		if (r > VMAX) r = VMAX;
		else if (r < VMIN) r = VMIN;
		return r;
	endfunction

	always_comb begin
		md    = 7'((8'(lo_q) + 8'(hi_q)) >> 1);
		point = axis_q ? qy_q : qx_q;
		ax_rd = axis_q ? y_rd : x_rd;
	end

	// Axis read address: search midpoint, then lo and hi of the bracket.
	always_comb begin
		case (state_q)
			gbi_pkg::ST_SRCH_RD:
				ax_raddr = (hi_q - lo_q <= 7'd1) ? AW'(lo_q) : AW'(md);
			gbi_pkg::ST_SPAN_RD:  ax_raddr = AW'(hi_q);
			default:              ax_raddr = AW'(lo_q);
		endcase
	end

	always_comb begin
		ylo_c = AW'(lo_q);
		yhi_c = AW'(hi_q);
		case (corner_q)
			2'd0:    g_raddr = {xlo_q, ylo_c};
			2'd1:    g_raddr = {xhi_q, ylo_c};
			2'd2:    g_raddr = {xlo_q, yhi_c};
			default: g_raddr = {xhi_q, yhi_c};
		endcase
	end

	assign ax_we   = accept && (opcode == gbi_pkg::OP_WRITE_X || opcode == gbi_pkg::OP_WRITE_Y)
		&& (int'(first_index) < MAX_POINTS);
	assign g_we    = accept && (opcode == gbi_pkg::OP_WRITE_GRID)
		&& (int'(first_index) < MAX_POINTS) && (int'(second_index) < MAX_POINTS);
	assign g_waddr = {AW'(first_index), AW'(second_index)};

	gbi_store #(.MAX_POINTS(MAX_POINTS), .VW(VW)) u_store (
		.clk      (clk),
		.ax_we    (ax_we),
		.ax_sel_y (opcode == gbi_pkg::OP_WRITE_Y),
		.ax_waddr (AW'(first_index)),
		.ax_raddr (ax_raddr),
		.wdata    (load_value[VW-1:0]),
		.x_rdata  (x_rd),
		.y_rdata  (y_rd),
		.g_we     (g_we),
		.g_waddr  (g_waddr),
		.g_raddr  (g_raddr),
		.g_rdata  (g_rd)
	);

	always_comb begin
		span = DW'(ax_rd) - DW'(alo_q);
		diff = DW'(point) - DW'(alo_q);
		dreq.start = (state_q == gbi_pkg::ST_SPAN_CAP) && (span != '0);
		dreq.num   = diff <<< 16;
		dreq.den   = span;
	end

	gbi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		if (drsp.quot > DW'(signed'(FB'(8388607)))) frac_sat = FB'(8388607);
		else if (drsp.quot < -DW'(8388608)) frac_sat = FB'(-8388608);
		else frac_sat = drsp.quot[FB-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbi_pkg::ST_IDLE:
				if (accept && opcode == gbi_pkg::OP_QUERY) state_d = gbi_pkg::ST_SRCH_RD;
			gbi_pkg::ST_SRCH_RD:
				if (hi_q - lo_q <= 7'd1) state_d = gbi_pkg::ST_SPAN_RD;
				else state_d = gbi_pkg::ST_SRCH_CMP;
			gbi_pkg::ST_SRCH_CMP:  state_d = gbi_pkg::ST_SRCH_RD;
			gbi_pkg::ST_SPAN_RD:   state_d = gbi_pkg::ST_SPAN_CAP;
			gbi_pkg::ST_SPAN_CAP:
				if (span == '0) state_d = axis_q ? gbi_pkg::ST_CORNER_RD : gbi_pkg::ST_SRCH_RD;
				else state_d = gbi_pkg::ST_DIV;
			gbi_pkg::ST_DIV:
				if (drsp.done) state_d = axis_q ? gbi_pkg::ST_CORNER_RD : gbi_pkg::ST_SRCH_RD;
			gbi_pkg::ST_CORNER_RD:
				if (cap_q == 3'd4) state_d = gbi_pkg::ST_ROW;
			gbi_pkg::ST_ROW:       state_d = gbi_pkg::ST_FINAL;
			gbi_pkg::ST_FINAL:     state_d = gbi_pkg::ST_DONE;
			gbi_pkg::ST_DONE:      state_d = gbi_pkg::ST_IDLE;
			default:               state_d = gbi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		valid        = (state_q == gbi_pkg::ST_DONE);
		interpolated = res_q;
		x_low_index  = 6'(xlo_q);
		y_low_index  = 6'(ylo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbi_pkg::ST_IDLE;
			xused_q <= 7'd64;
			yused_q <= 7'd64;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gbi_pkg::CFG_X_USED) xused_q <= cfg_data;
				else yused_q <= cfg_data;
			end
		end
	end

	// Finishes one axis: store its bracket and fraction, set up the next.
	always_comb frac_cur = (state_q == gbi_pkg::ST_DIV) ? frac_sat : HALF;

	always_ff @(posedge clk) begin
		case (state_q)
			gbi_pkg::ST_IDLE: begin
				qx_q   <= query_x;
				qy_q   <= query_y;
				axis_q <= 1'b0;
				lo_q   <= '0;
				if (xused_q == 7'd0) hi_q <= '0;
				else if (xused_q > 7'(REACH)) hi_q <= 7'(REACH - 1);
				else hi_q <= xused_q - 7'd1;
			end
			gbi_pkg::ST_SRCH_CMP: begin
				if (ax_rd > point) hi_q <= md;
				else lo_q <= md;
			end
			gbi_pkg::ST_SPAN_CAP: alo_q <= alo_q;
			default: ;
		endcase
		if (state_q == gbi_pkg::ST_SPAN_RD) alo_q <= ax_rd;
		if ((state_q == gbi_pkg::ST_SPAN_CAP && span == '0) ||
			(state_q == gbi_pkg::ST_DIV && drsp.done)) begin
			if (!axis_q) begin
				fx_q   <= frac_cur;
				xlo_q  <= AW'(lo_q);
				xhi_q  <= AW'(hi_q);
				axis_q <= 1'b1;
				lo_q   <= '0;
				if (yused_q == 7'd0) hi_q <= '0;
				else if (yused_q > 7'(REACH)) hi_q <= 7'(REACH - 1);
				else hi_q <= yused_q - 7'd1;
			end else begin
				fy_q  <= frac_cur;
				ylo_q <= AW'(lo_q);
			end
			corner_q <= 2'd0;
			cap_q    <= 3'd0;
		end
		if (state_q == gbi_pkg::ST_CORNER_RD) begin
			if (corner_q != 2'd3) corner_q <= corner_q + 2'd1;
			cap_q <= cap_q + 3'd1;
			case (cap_q)
				3'd1:    g00_q <= g_rd;
				3'd2:    g10_q <= g_rd;
				3'd3:    g01_q <= g_rd;
				default: ;
			endcase
			if (cap_q == 3'd4) begin
				row_lo_q <= blend(64'(g00_q), 64'(g10_q), fx_q);
				row_hi_q <= 64'(g_rd);
			end
		end
		if (state_q == gbi_pkg::ST_ROW)
			row_hi_q <= blend(64'(g01_q), row_hi_q, fx_q);
		if (state_q == gbi_pkg::ST_FINAL)
			res_q <= 32'(blend(row_lo_q, row_hi_q, fy_q));
	end

	`GBI_ASSERT_IMPL(a_valid_one_cycle, clk, arst_n, valid,
		$past(state_q) == gbi_pkg::ST_FINAL, "result word without blend")
	`GBI_ASSERT_NEXT(a_no_double_valid, clk, arst_n, valid, !valid, "result word repeated")
	`GBI_ASSERT_IMPL(a_bracket_order, clk, arst_n, state_q == gbi_pkg::ST_SRCH_RD,
		lo_q <= hi_q, "search bracket inverted")
endmodule
`default_nettype wire

// ===== tb/sv/tb_grid_bilinear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolator
// Self-checking bench: loads axes and grids, runs random and corner queries
// over several point-count settings, and checks each result word against an
// in-bench fixed-point model of the bracketing search and bilinear blend.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_grid_bilinear_interpolator;

	typedef struct {
		logic [1:0]         op;
		logic [5:0]         i1;
		logic [5:0]         i2;
		logic signed [31:0] lv;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
	} cmd_t;

	typedef struct {
		logic signed [31:0] value;
		logic [5:0]         xlo;
		logic [5:0]         ylo;
	} answer_t;

	localparam longint QMIN = -64'sd2147483648;
	localparam longint QMAX = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n;
	logic start, busy, valid, cfg_valid, cfg_ready;
	logic [1:0] opcode;
	logic [5:0] first_index, second_index, x_low_index, y_low_index;
	logic signed [31:0] load_value, query_x, query_y, interpolated;
	logic [0:0] cfg_index;
	logic [6:0] cfg_data;

	grid_bilinear_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .first_index(first_index), .second_index(second_index),
		.load_value(load_value), .query_x(query_x), .query_y(query_y),
		.valid(valid), .interpolated(interpolated),
		.x_low_index(x_low_index), .y_low_index(y_low_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mirror of the block's stores and registers.
	longint x_store[64], y_store[64], grid_store[64][64];
	logic [6:0] x_used_reg = 7'd64, y_used_reg = 7'd64;

	// Planned axis contents, used only to aim query points.
	longint x_plan[64], y_plan[64];

	cmd_t    cmd_q[$];
	answer_t answer_q[$];
	cmd_t    cur;
	int      n_pushed = 0, n_taken = 0, errs = 0, idle_pct = 25;
	logic    took = 1'b0;

	function automatic int eff_count(logic [6:0] r);
		if (r < 1) return 1;
		if (r > 64) return 64;
		return int'(r);
	endfunction

	function automatic longint floor_q16(longint v);
		longint q;
		q = v / 65536;
		if ((v % 65536) != 0 && v < 0) q--;
		return q;
	endfunction

	function automatic longint lerp_q16(longint a, longint b, longint f);
		longint r;
		r = floor_q16(a * 65536 + (b - a) * f + 32768);
		return r < QMIN ? QMIN : (r > QMAX ? QMAX : r);
	endfunction

	function automatic void find_bracket(input bit on_y, input int n, input longint p,
			output int lo, output int hi, output longint f);
		longint span, lo_v;
		int md;
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			md = (hi + lo) / 2;
			if ((on_y ? y_store[md] : x_store[md]) > p) hi = md;
			else lo = md;
		end
		lo_v = on_y ? y_store[lo] : x_store[lo];
		span = (on_y ? y_store[hi] : x_store[hi]) - lo_v;
		if (span == 0) f = 32768;
		else begin
			f = ((p - lo_v) * 65536) / span;
			if (f > 8388607) f = 8388607;
			if (f < -8388608) f = -8388608;
		end
	endfunction

	function automatic void apply_cmd(cmd_t c);
		int xl, xh, yl, yh;
		longint fx, fy, rlo, rhi;
		answer_t a;
		case (c.op)
			gbi_pkg::OP_WRITE_X: x_store[c.i1] = c.lv;
			gbi_pkg::OP_WRITE_Y: y_store[c.i1] = c.lv;
			gbi_pkg::OP_WRITE_GRID: grid_store[c.i1][c.i2] = c.lv;
			default: begin
				find_bracket(1'b0, eff_count(x_used_reg), c.qx, xl, xh, fx);
				find_bracket(1'b1, eff_count(y_used_reg), c.qy, yl, yh, fy);
				rlo = lerp_q16(grid_store[xl][yl], grid_store[xh][yl], fx);
				rhi = lerp_q16(grid_store[xl][yh], grid_store[xh][yh], fx);
				a.value = 32'(lerp_q16(rlo, rhi, fy));
				a.xlo = 6'(xl);
				a.ylo = 6'(yl);
				answer_q = {answer_q, a};
			end
		endcase
	endfunction

	// Driver: a new word goes out once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur = cmd_q.pop_front();
				opcode <= cur.op;
				first_index <= cur.i1;
				second_index <= cur.i2;
				load_value <= cur.lv;
				query_x <= cur.qx;
				query_y <= cur.qy;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		took <= start && !busy;
		if (arst_n && start && !busy) begin
			apply_cmd(cur);
			n_taken++;
		end
	end

	// Monitor: every result word must match the oldest prediction.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && valid) begin
			if (answer_q.size() == 0) begin
				$error("result word with nothing outstanding");
				errs++;
			end else begin
				e = answer_q.pop_front();
				if (interpolated !== e.value) begin
					$error("interpolated: expected %0d, got %0d", e.value, interpolated);
					errs++;
				end
				if (x_low_index !== e.xlo) begin
					$error("x_low_index: expected %0d, got %0d", e.xlo, x_low_index);
					errs++;
				end
				if (y_low_index !== e.ylo) begin
					$error("y_low_index: expected %0d, got %0d", e.ylo, y_low_index);
					errs++;
				end
			end
		end
	end

	task automatic push_cmd(logic [1:0] op, int i1, int i2, longint lv, longint qx, longint qy);
		cmd_t c;
		c.op = op;
		c.i1 = 6'(i1);
		c.i2 = 6'(i2);
		c.lv = 32'(lv);
		c.qx = 32'(qx);
		c.qy = 32'(qy);
		cmd_q = {cmd_q, c};
		n_pushed++;
	endtask

	task automatic push_write(logic [1:0] op, int i1, int i2, longint lv);
		push_cmd(op, i1, i2, lv, $urandom, $urandom);
	endtask

	task automatic push_query(longint qx, longint qy);
		push_cmd(gbi_pkg::OP_QUERY, $urandom_range(63), $urandom_range(63), $urandom, qx, qy);
	endtask

	task automatic drain();
		while (n_taken != n_pushed || answer_q.size() != 0) @(posedge clk);
		// Writes give no result, so allow a query's worth of time to settle.
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == gbi_pkg::CFG_X_USED) x_used_reg = val;
		else y_used_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint grid_word();
		case ($urandom_range(9))
			0: return QMAX;
			1: return QMIN;
			2, 3, 4: return longint'($signed($urandom));
			default: return longint'($urandom_range(1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic longint clamp32(longint v);
		return v < QMIN ? QMIN : (v > QMAX ? QMAX : v);
	endfunction

	function automatic longint aim(bit on_y, int n);
		longint a0, an, w;
		a0 = on_y ? y_plan[0] : x_plan[0];
		an = on_y ? y_plan[n-1] : x_plan[n-1];
		case ($urandom_range(9))
			0: return longint'($signed($urandom));
			1: return $urandom_range(1) ? QMAX : QMIN;
			2: return on_y ? y_plan[$urandom_range(n-1)] : x_plan[$urandom_range(n-1)];
			default: begin
				w = (an > a0 ? an - a0 : a0 - an) + 65536;
				if (w > 64'sd1073741824) w = 64'sd1073741824;
				return clamp32((an < a0 ? an : a0) - w / 4
					+ longint'($urandom_range(32'(w + w / 2))));
			end
		endcase
	endfunction

	// Loads both axes and the grid region in use, then issues queries with
	// some stray writes mixed in.
	task automatic run_setting(logic [6:0] rx, logic [6:0] ry, int queries, bit spread);
		int nx, ny, k;
		longint v;
		write_reg(gbi_pkg::CFG_X_USED, rx);
		write_reg(gbi_pkg::CFG_Y_USED, ry);
		nx = eff_count(rx);
		ny = eff_count(ry);
		for (int ax = 0; ax < 2; ax++) begin
			k = ax ? ny : nx;
			v = -(longint'(k) << 17) + longint'($urandom_range(1 << 16));
			for (int i = 0; i < k; i++) begin
				if (spread && k > 1) v = QMIN + (longint'(i) * (QMAX - QMIN)) / (k - 1);
				else if (i != 0) case ($urandom_range(19))
					0, 1, 2: ;  // equal neighbours
					3: v = v - longint'($urandom_range(1 << 16));
					default: v = v + longint'($urandom_range(1 << 18, 1));
				endcase
				if (ax) y_plan[i] = v;
				else x_plan[i] = v;
				push_write(ax ? gbi_pkg::OP_WRITE_Y : gbi_pkg::OP_WRITE_X, i,
					$urandom_range(63), v);
			end
		end
		for (int i = 0; i < nx; i++)
			for (int j = 0; j < ny; j++)
				push_write(gbi_pkg::OP_WRITE_GRID, i, j, grid_word());
		for (int q = 0; q < queries; q++) begin
			if ($urandom_range(9) == 0) begin
				k = $urandom_range(2);
				v = grid_word();
				if (k == 0 && $urandom_range(1)) x_plan[$urandom_range(63)] = v;
				push_write(2'(k), $urandom_range(63), $urandom_range(63), v);
			end
			push_query(aim(1'b0, nx), aim(1'b1, ny));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = gbi_pkg::OP_WRITE_X;
		first_index = '0;
		second_index = '0;
		load_value = '0;
		query_x = '0;
		query_y = '0;
		cfg_valid = 1'b0;
		cfg_index = gbi_pkg::CFG_X_USED;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full 64-point x axis, then directed corners: the ends of the axes,
		// points on entries, outside both ends, and the widest coordinates.
		run_setting(7'd64, 7'd2, 0, 1'b0);
		push_query(QMIN, QMIN);
		push_query(QMAX, QMAX);
		push_query(QMIN, QMAX);
		push_query(x_plan[0], y_plan[0]);
		push_query(x_plan[63], y_plan[1]);
		push_query(x_plan[31], y_plan[1]);
		push_query(x_plan[0] - 65536, y_plan[1] + 65536);
		push_query((x_plan[10] + x_plan[11]) / 2, (y_plan[0] + y_plan[1]) / 2);
		push_query(0, 0);
		push_query(-1, 1);
		drain();

		run_setting(7'd0, 7'd127, 30, 1'b0);
		run_setting(7'd1, 7'd1, 20, 1'b0);
		idle_pct = 55;
		run_setting(7'd127, 7'd0, 30, 1'b1);
		run_setting(7'd2, 7'd3, 60, 1'b0);
		run_setting(7'd6, 7'd5, 40, 1'b1);
		idle_pct = 0;
		for (int p = 0; p < 2; p++)
			run_setting(7'($urandom_range(6)), 7'($urandom_range(6)), 20, p[0]);
		run_setting(7'd3, 7'd3, 20, 1'b0);

		if (errs == 0) begin
			$display("tb_grid_bilinear_interpolator OK");
		end else begin
			$display("tb_grid_bilinear_interpolator NOT OK");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("tb_grid_bilinear_interpolator NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/gbi_pkg.sv
rtl/gbi_divider.sv
rtl/gbi_store.sv
rtl/grid_bilinear_interpolator.sv
tb/sv/tb_grid_bilinear_interpolator.sv
